### design/srlp_pkg.sv
// Shared types and constants for the S-record line parser.
package srlp_pkg;

  typedef enum logic [2:0] {
    PH_WAIT, PH_TAG, PH_LEN, PH_BODY, PH_EOL
  } phase_t;

  localparam logic [1:0] RK_PAYLOAD  = 2'd0;
  localparam logic [1:0] RK_ACCEPT   = 2'd1;
  localparam logic [1:0] RK_ERROR    = 2'd2;
  localparam logic [1:0] RK_COMPLETE = 2'd3;

  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_DATA    = 3'd1;
  localparam logic [2:0] KIND_COUNT   = 3'd2;
  localparam logic [2:0] KIND_START   = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  localparam logic [4:0] ERR_NONE       = 5'd0;
  localparam logic [4:0] ERR_GARBAGE    = 5'd1;
  localparam logic [4:0] ERR_BAD_LEN    = 5'd2;
  localparam logic [4:0] ERR_CHECKSUM   = 5'd3;
  localparam logic [4:0] ERR_EOL        = 5'd4;
  localparam logic [4:0] ERR_SHORT      = 5'd5;
  localparam logic [4:0] ERR_TYPE       = 5'd6;
  localparam logic [4:0] ERR_NO_HEADER  = 5'd7;
  localparam logic [4:0] ERR_NOT_LAST   = 5'd8;
  localparam logic [4:0] ERR_DUP_HEADER = 5'd9;
  localparam logic [4:0] ERR_HDR_ADDR   = 5'd10;
  localparam logic [4:0] ERR_EMPTY_DATA = 5'd11;
  localparam logic [4:0] ERR_COUNT      = 5'd12;
  localparam logic [4:0] ERR_TERM_DATA  = 5'd13;
  localparam logic [4:0] ERR_DUP_TERM   = 5'd14;
  localparam logic [4:0] ERR_NO_DATA    = 5'd15;
  localparam logic [4:0] ERR_NO_TERM    = 5'd16;
  localparam logic [4:0] ERR_BAD_HEX    = 5'd17;

  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] SUM_OK  = 8'hFF;

  // Classified character, passed from front to back.
  typedef struct packed {
    logic       eoi;
    logic       is_s;
    logic       is_nl;
    logic       hex_ok;
    logic [3:0] hex;
  } cls_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  record_kind;
    logic [31:0] byte_address;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_length;
    logic [4:0]  error_code;
  } res_t;

  function automatic logic [2:0] tag_kind(input logic [3:0] tag);
    logic [2:0] k;
    begin
      k = KIND_UNKNOWN;
      if (tag == 4'd0) k = KIND_HEADER;
      else if (tag >= 4'd1 && tag <= 4'd3) k = KIND_DATA;
      else if (tag == 4'd5 || tag == 4'd6) k = KIND_COUNT;
      else if (tag >= 4'd7 && tag <= 4'd9) k = KIND_START;
      return k;
    end
  endfunction

  function automatic logic [2:0] addr_size(input logic [3:0] tag, input logic [7:0] len);
    logic [2:0] n;
    begin
      n = 3'd2;
      if (tag == 4'd0) n = (len < 8'd2) ? len[2:0] : 3'd2;
      else if (tag == 4'd2 || tag == 4'd8) n = 3'd3;
      else if (tag == 4'd3 || tag == 4'd7) n = 3'd4;
      else if (tag == 4'd5) n = (len >= 8'd2 && len <= 8'd4) ? len[2:0] : 3'd2;
      else if (tag == 4'd6) n = (len == 8'd4) ? 3'd4 : 3'd3;
      return n;
    end
  endfunction

endpackage

### design/srlp_front.sv
// Input stage: accept characters and classify them into a two-entry queue.
`default_nettype none
module srlp_front
  import srlp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_input,
  output logic            q_valid,
  output cls_t            q_data,
  input  wire logic       q_take
);

  cls_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cls_t       cls;
  logic       push;

  always_comb begin
    cls.eoi    = end_of_input;
    cls.is_s   = (char_code == CHAR_S);
    cls.is_nl  = (char_code == CHAR_NL);
    cls.hex_ok = 1'b1;
    cls.hex    = 4'd0;
    if (char_code >= 8'h30 && char_code <= 8'h39) cls.hex = 4'(char_code - 8'h30);
    else if (char_code >= 8'h41 && char_code <= 8'h46) cls.hex = 4'(char_code - 8'h37);
    else if (char_code >= 8'h61 && char_code <= 8'h66) cls.hex = 4'(char_code - 8'h57);
    else cls.hex_ok = 1'b0;
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= cls;
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_take) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_take);
    end
  end

endmodule
`default_nettype wire

### design/srlp_back.sv
// Parse engine: line state machine, checks and result register.
`default_nettype none
module srlp_back
  import srlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [3:0]  shift_amt,
  input  wire logic        q_valid,
  input  cls_t             q_data,
  output logic             q_take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output res_t             out_res
);

  phase_t      phase, phase_next;
  logic [3:0]  tag, tag_next;
  logic [4:0]  hn, hn_next;
  logic [7:0]  remaining, remaining_next;
  logic [2:0]  naddr, naddr_next;
  logic [31:0] acc, acc_next;
  logic [7:0]  pidx, pidx_next;
  logic [7:0]  sum, sum_next;
  logic [31:0] dcount, dcount_next;
  logic [2:0]  seen, seen_next;
  logic        err, err_next;
  logic        emit;
  res_t        res;

  logic [7:0]  b, len, plen;
  logic [2:0]  kind;
  logic [31:0] sh, mask;
  logic        adv;

  // Advance when a character is queued and the result slot is free or draining.
  assign adv    = q_valid && (!out_valid || out_ready);
  assign q_take = adv;

  always_comb begin
    phase_next = phase; tag_next = tag; hn_next = hn; remaining_next = remaining;
    naddr_next = naddr; acc_next = acc; pidx_next = pidx; sum_next = sum;
    dcount_next = dcount; seen_next = seen; err_next = err;
    emit = 1'b0;
    res = '0;
    b    = {hn[3:0], q_data.hex};
    kind = tag_kind(tag);
    sh   = acc << shift_amt;
    len  = pidx - 8'd1;
    plen = len - 8'(naddr);
    mask = 32'hFFFF_FFFF;
    if (acc <= 32'h0000_FFFF) mask = 32'h0000_FFFF;
    else if (acc <= 32'h00FF_FFFF) mask = 32'h00FF_FFFF;
    if (adv && !err) begin
      unique case (phase)
        PH_WAIT: begin
          if (q_data.eoi) begin
            emit = 1'b1;
            if (!seen[0]) res.error_code = ERR_NO_HEADER;
            else if (dcount == 32'd0) res.error_code = ERR_NO_DATA;
            else if (!seen[1]) res.error_code = ERR_NO_TERM;
            res.result_kind = (res.error_code == ERR_NONE) ? RK_COMPLETE : RK_ERROR;
          end else if (q_data.is_s) phase_next = PH_TAG;
          else if (!q_data.is_nl) begin
            emit = 1'b1; res.result_kind = RK_ERROR; res.error_code = ERR_GARBAGE;
          end
        end
        PH_TAG: begin
          if (q_data.eoi || !q_data.hex_ok) begin
            emit = 1'b1; res.result_kind = RK_ERROR; res.error_code = ERR_BAD_HEX;
          end else begin
            tag_next = q_data.hex; sum_next = 8'd0; hn_next = 5'd0; phase_next = PH_LEN;
          end
        end
        PH_LEN, PH_BODY: begin
          if (q_data.eoi || !q_data.hex_ok) begin
            emit = 1'b1; res.result_kind = RK_ERROR; res.error_code = ERR_BAD_HEX;
          end else if (!hn[4]) begin
            hn_next = {1'b1, q_data.hex};
          end else begin
            hn_next  = 5'd0;
            sum_next = sum + b;
            if (phase == PH_LEN) begin
              if (b == 8'd0) begin
                emit = 1'b1; res.result_kind = RK_ERROR; res.error_code = ERR_BAD_LEN;
              end else begin
                remaining_next = b; pidx_next = 8'd0; acc_next = 32'd0;
                naddr_next = addr_size(tag, b - 8'd1); phase_next = PH_BODY;
              end
            end else begin
              if (pidx < 8'(naddr)) acc_next = {acc[23:0], b};
              pidx_next = pidx + 8'd1;
              remaining_next = remaining - 8'd1;
              if (remaining == 8'd1) begin
                phase_next = PH_EOL;
                if (sum + b != SUM_OK) begin
                  emit = 1'b1; res.result_kind = RK_ERROR; res.error_code = ERR_CHECKSUM;
                end
              end else if ((kind == KIND_HEADER || kind == KIND_DATA)
                           && pidx >= 8'(naddr)) begin
                emit = 1'b1;
                res.result_kind  = RK_PAYLOAD;
                res.record_kind  = kind[1:0];
                res.byte_address = sh + 32'(pidx - 8'(naddr));
                res.payload_byte = b;
              end
            end
          end
        end
        PH_EOL: begin
          emit = 1'b1;
          res.result_kind = RK_ERROR;
          if (q_data.eoi || !q_data.is_nl) res.error_code = ERR_EOL;
          else begin
            phase_next = PH_WAIT;
            if (len < 8'(naddr)) res.error_code = ERR_SHORT;
            else begin
              seen_next[2] = 1'b1;
              if (kind != KIND_HEADER && !seen[0]) res.error_code = ERR_NO_HEADER;
              else if (kind != KIND_START && seen[1]) res.error_code = ERR_NOT_LAST;
              else begin
                unique case (kind)
                  KIND_HEADER: begin
                    if (seen[0]) res.error_code = ERR_DUP_HEADER;
                    else if (sh != 32'd0) res.error_code = ERR_HDR_ADDR;
                    else begin
                      seen_next[0] = 1'b1;
                      res.record_kind = KIND_HEADER[1:0];
                      res.payload_length = plen;
                    end
                  end
                  KIND_DATA: begin
                    dcount_next = dcount + 32'd1;
                    if (plen == 8'd0) res.error_code = ERR_EMPTY_DATA;
                    else begin
                      res.record_kind = KIND_DATA[1:0];
                      res.byte_address = sh;
                      res.payload_length = plen;
                    end
                  end
                  KIND_COUNT: begin
                    if (acc != (mask & dcount)) res.error_code = ERR_COUNT;
                    else begin
                      res.record_kind = KIND_COUNT[1:0];
                      res.byte_address = acc;
                      res.payload_length = plen;
                    end
                  end
                  KIND_START: begin
                    if (plen != 8'd0) res.error_code = ERR_TERM_DATA;
                    else if (seen[1]) res.error_code = ERR_DUP_TERM;
                    else begin
                      seen_next[1] = 1'b1;
                      res.record_kind = KIND_START[1:0];
                      res.byte_address = sh;
                    end
                  end
                  default: res.error_code = ERR_TYPE;
                endcase
              end
            end
            if (res.error_code == ERR_NONE) res.result_kind = RK_ACCEPT;
          end
        end
        default: phase_next = PH_WAIT;
      endcase
      if (emit && res.result_kind == RK_ERROR) err_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) out_res <= res;
    if (rst) begin
      phase <= PH_WAIT; tag <= 4'd0; hn <= 5'd0; remaining <= 8'd0; naddr <= 3'd2;
      acc <= 32'd0; pidx <= 8'd0; sum <= 8'd0; dcount <= 32'd0; seen <= 3'd0;
      err <= 1'b0; out_valid <= 1'b0;
    end else begin
      phase <= phase_next; tag <= tag_next; hn <= hn_next; remaining <= remaining_next;
      naddr <= naddr_next; acc <= acc_next; pidx <= pidx_next; sum <= sum_next;
      dcount <= dcount_next; seen <= seen_next; err <= err_next;
      if (adv) out_valid <= emit;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### design/srecord_line_parser_top.sv
// Top level of the S-record line parser.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, char_code, end_of_input | in
//  output  | out_valid, out_ready, result_kind .. error_code | out
//  config  | cfg_we, cfg_wdata (addr_shift_amount)    | in
//
// One character per cycle sustained while the output is not stalled: the front
// classifies a character into a two-entry queue and the back parse engine
// retires one queued character per cycle, setting the rate. A character is
// registered in the queue and its result in the output register. Reset clears
// all parse state, the queue, the shift register and the result valid flag.
// A stalled output holds the engine; the queue lets the input take up to two
// more characters before in_ready drops.
`default_nettype none
module srecord_line_parser_top
  import srlp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       result_kind,
  output logic [1:0]       record_kind,
  output logic [31:0]      byte_address,
  output logic [7:0]       payload_byte,
  output logic [7:0]       payload_length,
  output logic [4:0]       error_code
);

  logic [3:0] addr_shift_amount;
  logic       q_valid, q_take;
  cls_t       q_data;
  res_t       res;

  // Hold the shift amount; the user must write it only while idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) addr_shift_amount <= 4'd0;
    else if (cfg_we) addr_shift_amount <= cfg_wdata;
  end

  srlp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .char_code, .end_of_input,
    .q_valid, .q_data, .q_take
  );

  srlp_back u_back (
    .clk, .rst, .shift_amt(addr_shift_amount), .q_valid, .q_data, .q_take,
    .out_valid, .out_ready, .out_res(res)
  );

  assign result_kind    = res.result_kind;
  assign record_kind    = res.record_kind;
  assign byte_address   = res.byte_address;
  assign payload_byte   = res.payload_byte;
  assign payload_length = res.payload_length;
  assign error_code     = res.error_code;

endmodule
`default_nettype wire

### bench/srecord_line_parser_top_tb.sv
// Self-checking bench for the S-record line parser: predicts every result per character.
`default_nettype none
module srecord_line_parser_top_tb;
  import srlp_pkg::*;

  // Hex digit value of a character, -1 when it is not a hex digit.
  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  // Tracks parser state per character and holds the results still owed by the block.
  class srec_scoreboard;
    res_t       owed[$];
    int         fails;
    phase_t     ph;
    logic [3:0] tag;
    logic [4:0] nib;
    logic [7:0] left;
    logic [2:0] naddr;
    logic [31:0] acc;
    logic [7:0] idx;
    logic [7:0] sum;
    logic [31:0] dcount;
    logic [2:0] seen;
    logic       dead;
    logic [3:0] shamt;

    function new();
      fails = 0; ph = PH_WAIT; tag = 0; nib = 0; left = 0; naddr = 3'd2; acc = 0;
      idx = 0; sum = 0; dcount = 0; seen = 0; dead = 0; shamt = 0;
    endfunction

    function logic [2:0] kind_of(logic [3:0] t);
      case (t)
        4'd0: return KIND_HEADER;
        4'd1, 4'd2, 4'd3: return KIND_DATA;
        4'd5, 4'd6: return KIND_COUNT;
        4'd7, 4'd8, 4'd9: return KIND_START;
        default: return KIND_UNKNOWN;
      endcase
    endfunction

    function logic [2:0] addr_bytes(logic [3:0] t, int len);
      case (t)
        4'd0: return (len < 2) ? 3'(len) : 3'd2;
        4'd2, 4'd8: return 3'd3;
        4'd3, 4'd7: return 3'd4;
        4'd5: return (len >= 2 && len <= 4) ? 3'(len) : 3'd2;
        4'd6: return (len == 4) ? 3'd4 : 3'd3;
        default: return 3'd2;
      endcase
    endfunction

    function void emit(logic [1:0] rk, logic [1:0] kd, logic [31:0] a, logic [7:0] b,
                       logic [7:0] n, logic [4:0] e);
      res_t r;
      r.result_kind = rk; r.record_kind = kd; r.byte_address = a;
      r.payload_byte = b; r.payload_length = n; r.error_code = e;
      owed.push_back(r);
    endfunction

    function void raise(logic [4:0] e);
      dead = 1;
      emit(RK_ERROR, 2'd0, 32'd0, 8'd0, 8'd0, e);
    endfunction

    // Line checks at the newline, applied in order.
    function void close_line();
      int len, plen;
      logic [2:0] k;
      logic [31:0] mask;
      ph = PH_WAIT;
      len = int'(idx) - 1;
      if (len < int'(naddr)) begin raise(ERR_SHORT); return; end
      plen = len - int'(naddr);
      seen[2] = 1;
      k = kind_of(tag);
      if (k != KIND_HEADER && !seen[0]) begin raise(ERR_NO_HEADER); return; end
      if (k != KIND_START && seen[1]) begin raise(ERR_NOT_LAST); return; end
      case (k)
        KIND_HEADER: begin
          if (seen[0]) raise(ERR_DUP_HEADER);
          else if ((acc << shamt) != 0) raise(ERR_HDR_ADDR);
          else begin
            seen[0] = 1;
            emit(RK_ACCEPT, 2'(KIND_HEADER), 32'd0, 8'd0, 8'(plen), ERR_NONE);
          end
        end
        KIND_DATA: begin
          dcount++;
          if (plen == 0) raise(ERR_EMPTY_DATA);
          else emit(RK_ACCEPT, 2'(KIND_DATA), acc << shamt, 8'd0, 8'(plen), ERR_NONE);
        end
        KIND_COUNT: begin
          mask = 32'hFFFF;
          while (acc > mask) mask = (mask << 8) | 32'hFF;
          if (acc != (mask & dcount)) raise(ERR_COUNT);
          else emit(RK_ACCEPT, 2'(KIND_COUNT), acc, 8'd0, 8'(plen), ERR_NONE);
        end
        KIND_START: begin
          if (plen > 0) raise(ERR_TERM_DATA);
          else if (seen[1]) raise(ERR_DUP_TERM);
          else begin
            seen[1] = 1;
            emit(RK_ACCEPT, 2'(KIND_START), acc << shamt, 8'd0, 8'd0, ERR_NONE);
          end
        end
        default: raise(ERR_TYPE);
      endcase
    endfunction

    // Advance the prediction by one accepted character.
    function void note_char(logic [7:0] c, logic eoi);
      int v;
      logic [7:0] b, j;
      logic [2:0] k;
      if (dead) return;
      v = eoi ? -1 : hex_digit(c);
      case (ph)
        PH_WAIT: begin
          if (eoi) begin
            if (!seen[0]) raise(ERR_NO_HEADER);
            else if (dcount == 0) raise(ERR_NO_DATA);
            else if (!seen[1]) raise(ERR_NO_TERM);
            else emit(RK_COMPLETE, 2'd0, 32'd0, 8'd0, 8'd0, ERR_NONE);
          end else if (c == CHAR_S) ph = PH_TAG;
          else if (c != CHAR_NL) raise(ERR_GARBAGE);
        end
        PH_TAG: begin
          if (v < 0) raise(ERR_BAD_HEX);
          else begin
            tag = v[3:0]; sum = 0; nib = 0; ph = PH_LEN;
          end
        end
        PH_LEN, PH_BODY: begin
          if (v < 0) begin raise(ERR_BAD_HEX); return; end
          if (!nib[4]) begin nib = {1'b1, v[3:0]}; return; end
          b = {nib[3:0], v[3:0]};
          nib = 0;
          sum = sum + b;
          if (ph == PH_LEN) begin
            if (b == 0) begin raise(ERR_BAD_LEN); return; end
            left = b; idx = 0; acc = 0;
            naddr = addr_bytes(tag, int'(b) - 1);
            ph = PH_BODY;
            return;
          end
          j = idx;
          if (j < naddr) acc = {acc[23:0], b};
          idx = j + 1;
          left = left - 1;
          if (left == 0) begin
            ph = PH_EOL;
            if (sum != SUM_OK) raise(ERR_CHECKSUM);
            return;
          end
          k = kind_of(tag);
          if ((k == KIND_HEADER || k == KIND_DATA) && j >= naddr)
            emit(RK_PAYLOAD, k[1:0], (acc << shamt) + (32'(j) - 32'(naddr)), b, 8'd0, ERR_NONE);
        end
        PH_EOL: begin
          if (eoi || c != CHAR_NL) raise(ERR_EOL);
          else close_line();
        end
        default: ph = PH_WAIT;
      endcase
    endfunction

    function void check(res_t got);
      res_t w;
      if (owed.size() == 0) begin
        fails++;
        $display("%0t: unexpected result %h", $realtime, got);
        return;
      end
      w = owed.pop_front();
      if (got.result_kind != w.result_kind) begin
        fails++;
        $display("%0t: result_kind exp %0d got %0d", $realtime, w.result_kind, got.result_kind);
      end
      if (got.record_kind != w.record_kind) begin
        fails++;
        $display("%0t: record_kind exp %0d got %0d", $realtime, w.record_kind, got.record_kind);
      end
      if (got.byte_address != w.byte_address) begin
        fails++;
        $display("%0t: byte_address exp %h got %h", $realtime, w.byte_address, got.byte_address);
      end
      if (got.payload_byte != w.payload_byte) begin
        fails++;
        $display("%0t: payload_byte exp %h got %h", $realtime, w.payload_byte, got.payload_byte);
      end
      if (got.payload_length != w.payload_length) begin
        fails++;
        $display("%0t: payload_length exp %0d got %0d", $realtime, w.payload_length,
                 got.payload_length);
      end
      if (got.error_code != w.error_code) begin
        fails++;
        $display("%0t: error_code exp %0d got %0d", $realtime, w.error_code, got.error_code);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [3:0]  cfg_wdata = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  char_code = 0;
  logic        end_of_input = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  result_kind, record_kind;
  logic [31:0] byte_address;
  logic [7:0]  payload_byte, payload_length;
  logic [4:0]  error_code;

  srec_scoreboard sb = new();
  int  send_idle = 0;    // percent of cycles the sender holds off
  int  recv_stall = 0;   // percent of cycles the receiver stalls
  bit  hold_req = 0;     // ask the receiver for one long hold-off
  int  sent = 0;

  srecord_line_parser_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .char_code(char_code),
    .end_of_input(end_of_input), .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .record_kind(record_kind), .byte_address(byte_address),
    .payload_byte(payload_byte), .payload_length(payload_length), .error_code(error_code)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Receiver: random stalls, plus one long hold-off on request so the input backs up.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      out_ready <= 1'b0;
      repeat (300) @(posedge clk);
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Result monitor: sample the output transfer at the edge, before the block updates.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check('{result_kind, record_kind, byte_address, payload_byte, payload_length,
                 error_code});
  end

  // Offer one character and hold it until the transfer; note it in the predictor then.
  task automatic put_char(logic [7:0] c, logic eoi);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, eoi);
    sent++;
  endtask

  // Hex digit character; letters come in either case.
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return 8'("0") + 8'(n);
    return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  task automatic put_byte(logic [7:0] b);
    put_char(hex_char(b[7:4]), 1'b0);
    put_char(hex_char(b[3:0]), 1'b0);
  endtask

  // Send one line: S and tag, count, body (address then payload), checksum, newline if end_nl.
  task automatic put_line(logic [3:0] tag, logic [7:0] body[$], bit bad_sum, bit end_nl);
    logic [7:0] cnt, s;
    cnt = 8'(body.size() + 1);
    s = cnt;
    put_char(CHAR_S, 1'b0);
    put_char(hex_char(tag), 1'b0);
    put_byte(cnt);
    foreach (body[i]) begin
      put_byte(body[i]);
      s = s + body[i];
    end
    put_byte(bad_sum ? s : ~s);
    if (end_nl) put_char(CHAR_NL, 1'b0);
  endtask

  task automatic put_addr_rec(logic [3:0] tag, int nab, logic [31:0] a, int plen);
    logic [7:0] body[$];
    for (int i = nab - 1; i >= 0; i--) body.push_back(a[i*8 +: 8]);
    repeat (plen) body.push_back(8'($urandom));
    put_line(tag, body, 1'b0, 1'b1);
  endtask

  task automatic put_data();
    int tg, plen;
    tg = $urandom_range(1, 3);
    plen = ($urandom_range(40) == 0) ? $urandom_range(1, 253 - tg) : $urandom_range(1, 12);
    put_addr_rec(4'(tg), tg + 1, $urandom, plen);
  endtask

  // Data-count record that matches the current count.
  task automatic put_count();
    int nab;
    if ($urandom_range(1)) begin
      nab = $urandom_range(2, 4);
      put_addr_rec(4'd5, nab, sb.dcount & ((nab == 4) ? 32'hFFFFFFFF :
                   (nab == 3) ? 32'hFFFFFF : 32'hFFFF), 0);
    end else begin
      put_addr_rec(4'd6, 3, sb.dcount & 32'hFFFFFF, 0);
    end
  endtask

  // Lower valid and wait until every owed result has come, then let the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_shift(logic [3:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.shamt = v;
  endtask

  initial begin
    int pick, start, r;
    logic [7:0] body[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_shift(4'd0);

    // Header in one of its forms: one address byte, or two with or without payload.
    pick = $urandom_range(2);
    if (pick == 0) put_addr_rec(4'd0, 1, 32'd0, 0);
    else if (pick == 1) put_addr_rec(4'd0, 2, 32'd0, 0);
    else begin
      body = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h48};
      put_line(4'd0, body, 1'b0, 1'b1);
    end
    put_char(CHAR_NL, 1'b0);
    put_addr_rec(4'd1, 2, 32'hFFFF, 1);
    put_addr_rec(4'd2, 3, 32'hFFFFFF, 2);
    put_addr_rec(4'd3, 4, 32'hFFFFFFFF, 3);
    put_addr_rec(4'd3, 4, 32'h0, 1);
    put_addr_rec(4'd5, 2, sb.dcount, 0);
    put_addr_rec(4'd5, 3, sb.dcount, 0);
    put_addr_rec(4'd5, 4, sb.dcount, 0);
    put_addr_rec(4'd5, 2, sb.dcount, 3);   // count with trailing bytes
    put_addr_rec(4'd6, 3, sb.dcount, 0);
    put_addr_rec(4'd6, 4, sb.dcount, 0);
    drain();

    // Random phases under different shifts and idling patterns.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin set_shift(4'd15); send_idle = 0;  recv_stall = 0;  hold_req = 1; end
        1: begin set_shift(4'd8);  send_idle = 66; recv_stall = 0;  end
        2: begin set_shift(4'($urandom)); send_idle = 0; recv_stall = 66; end
        default: begin set_shift(4'($urandom)); send_idle = 9; recv_stall = 9; end
      endcase
      start = sent;
      while (sent - start < 350) begin
        r = $urandom_range(99);
        if (r < 80) put_data();
        else if (r < 90) put_count();
        else put_char(CHAR_NL, 1'b0);
      end
      drain();
    end

    // Close the file for most picks, then break it in one way; errors stick so this comes last.
    send_idle = 9; recv_stall = 9;
    pick = $urandom_range(14);
    if (!(pick inside {6, 7, 8, 9, 13})) begin
      // Termination record with the address width its type calls for.
      r = $urandom_range(7, 9);
      put_addr_rec(4'(r), 11 - r, $urandom, 0);
      put_char(8'($urandom), 1'b1);
      put_char(8'($urandom), 1'b1);
    end
    case (pick)
      0: put_char(8'h78, 1'b0);
      1: begin put_char(CHAR_S, 1'b0); put_char(8'h47, 1'b0); end
      2: begin put_char(CHAR_S, 1'b0); put_char(8'h31, 1'b0); put_byte(8'h00); end
      3: begin body = '{8'h12, 8'h34, 8'h56}; put_line(4'd1, body, 1'b1, 1'b1); end
      4: begin body = '{8'h00, 8'h00}; put_line(4'd9, body, 1'b0, 1'b0);
               put_char(8'h51, 1'b0); end
      5: begin body = '{8'h12}; put_line(4'd1, body, 1'b0, 1'b1); end
      6: put_addr_rec(4'($urandom_range(10, 15)), 2, 32'd0, 1);
      7: put_addr_rec(4'd0, 2, 32'd0, 0);
      8: put_addr_rec(4'd1, 2, $urandom, 0);
      9: put_addr_rec(4'd5, 3, sb.dcount + 32'h10000, 0);
      10: put_addr_rec(4'd9, 2, 32'd0, 1);
      11: put_addr_rec(4'd8, 3, 32'd0, 0);
      12: put_data();
      13: put_char(8'd0, 1'b1);
      default: begin put_char(CHAR_S, 1'b0); put_char(8'h31, 1'b0); put_char(8'd0, 1'b1); end
    endcase
    // Anything after the error must be ignored.
    repeat (40) put_char(8'($urandom), 1'($urandom_range(3) == 0));
    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.owed.size() == 0) $display("srecord_line_parser_top: match");
    else $display("srecord_line_parser_top: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("srecord_line_parser_top: mismatch");
    $finish;
  end

endmodule

### filelist.f
design/srlp_pkg.sv
design/srlp_front.sv
design/srlp_back.sv
design/srecord_line_parser_top.sv
bench/srecord_line_parser_top_tb.sv
